[sv/lfu_pkg.sv]
// Package for the LFU cache: widths, defaults, command codes.
// No dependencies.
`default_nettype none
package lfu_pkg;
  localparam int CAPACITY_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int KEY_W = 32;
  localparam int CAP_CFG_W = 5;
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;
  localparam logic [CAP_CFG_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic cmd;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [KEY_W-1:0] store_value;
  } req_t;

  typedef struct packed {
    logic hit;
    logic signed [KEY_W-1:0] read_data;
    logic evicted;
    logic signed [KEY_W-1:0] evicted_key;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, clear scan state
    logic scan;      // examine entry at scan index
    logic commit;    // apply update, build result
  } lfu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done; // scan index is on the last entry
  } lfu_sts_t;
endpackage
`default_nettype wire

[sv/lfu_if.sv]
// Valid/ready channel interface carrying a request or result payload.
// Depends on lfu_pkg.
`default_nettype none
interface lfu_req_if;
  import lfu_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lfu_rsp_if;
  import lfu_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/lfu_ctrl.sv]
// Controller for the LFU cache: load, entry scan, commit, result hand-off.
// Depends on lfu_pkg.
`default_nettype none
module lfu_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  input  wire logic           out_busy,
  input  wire lfu_pkg::lfu_sts_t sts,
  output lfu_pkg::lfu_cmd_t   cmd,
  output logic                idle
);
  import lfu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_WAIT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (!out_busy) begin
          cmd.commit = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!out_busy) begin
          cmd.commit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign idle = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

[sv/lfu_dp.sv]
// Datapath for the LFU cache: entry registers, serial match/victim/free scan,
// recency update and result register. Depends on lfu_pkg.
`default_nettype none
module lfu_dp #(
  parameter int CAPACITY    = lfu_pkg::CAPACITY_DEF,
  parameter int COUNT_WIDTH = lfu_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire lfu_pkg::lfu_cmd_t              cmd,
  input  wire lfu_pkg::req_t                  req,
  input  wire logic [lfu_pkg::CAP_CFG_W-1:0]  cap_cfg,
  output lfu_pkg::lfu_sts_t                   sts,
  output lfu_pkg::rsp_t                       rsp
);
  import lfu_pkg::*;
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int RW = $clog2(CAPACITY + 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [CAPACITY-1:0] valid_r;
  logic [KEY_W-1:0] key_r [CAPACITY];
  logic [KEY_W-1:0] val_r [CAPACITY];
  logic [COUNT_WIDTH-1:0] cnt_r [CAPACITY];
  logic [RW-1:0] rank_r [CAPACITY];
  logic [RW-1:0] occ_r;

  req_t req_r;
  logic [IW-1:0] pos_r;
  logic hit_r, vic_ok_r, free_ok_r;
  logic [IW-1:0] hit_idx_r, vic_idx_r, free_idx_r;
  logic [COUNT_WIDTH-1:0] vic_cnt_r;
  logic [RW-1:0] vic_rank_r;

  // effective capacity, saturated to storage size
  logic [RW-1:0] cap_eff;
  always_comb begin
    if (32'(cap_cfg) > CAPACITY) cap_eff = RW'(CAPACITY);
    else cap_eff = RW'(cap_cfg);
  end

  // scan of one entry a cycle
  logic cur_v;
  logic better;
  assign cur_v = valid_r[pos_r];
  assign better = !vic_ok_r || (cnt_r[pos_r] < vic_cnt_r) ||
                  (cnt_r[pos_r] == vic_cnt_r && rank_r[pos_r] < vic_rank_r);

  // only looked at while scanning
  assign sts.scan_done = (32'(pos_r) == CAPACITY - 1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req;
      pos_r <= '0;
      hit_r <= 1'b0;
      vic_ok_r <= 1'b0;
      free_ok_r <= 1'b0;
    end else if (cmd.scan) begin
      if (!sts.scan_done) pos_r <= pos_r + 1'b1;
      if (cur_v && key_r[pos_r] == req_r.lookup_key && !hit_r) begin
        hit_r <= 1'b1;
        hit_idx_r <= pos_r;
      end
      if (cur_v && better) begin
        vic_ok_r <= 1'b1;
        vic_idx_r <= pos_r;
        vic_cnt_r <= cnt_r[pos_r];
        vic_rank_r <= rank_r[pos_r];
      end
      if (!cur_v && !free_ok_r) begin
        free_ok_r <= 1'b1;
        free_idx_r <= pos_r;
      end
    end
  end

  // commit decisions
  logic is_put, do_touch, do_evict, do_ins;
  logic [IW-1:0] ins_idx;
  logic [RW-1:0] occ_mid, ref_rank;
  always_comb begin
    is_put = (req_r.cmd == CMD_PUT);
    do_touch = hit_r && (!is_put || cap_eff != '0);
    do_evict = is_put && cap_eff != '0 && !hit_r && occ_r >= cap_eff && vic_ok_r;
    do_ins = is_put && cap_eff != '0 && !hit_r;
    // victim slot is the lowest free one if no lower free slot exists
    if (do_evict && (!free_ok_r || vic_idx_r < free_idx_r)) ins_idx = vic_idx_r;
    else ins_idx = free_idx_r;
    occ_mid = do_evict ? occ_r - 1'b1 : occ_r;
    ref_rank = do_touch ? rank_r[hit_idx_r] : vic_rank_r;
    if (do_ins && !do_evict && !free_ok_r) do_ins = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r <= '0;
    end else if (cmd.commit) begin
      for (int j = 0; j < CAPACITY; j++) begin
        if (valid_r[j] && (do_touch || do_evict) && rank_r[j] > ref_rank)
          rank_r[j] <= rank_r[j] - 1'b1;
      end
      if (do_touch) begin
        rank_r[hit_idx_r] <= (occ_r != '0) ? occ_r - 1'b1 : '0;
        if (cnt_r[hit_idx_r] != CNT_MAX) cnt_r[hit_idx_r] <= cnt_r[hit_idx_r] + 1'b1;
        if (is_put) val_r[hit_idx_r] <= req_r.store_value;
      end
      // a victim slot reused by the insert stays valid
      if (do_evict && !(do_ins && ins_idx == vic_idx_r)) valid_r[vic_idx_r] <= 1'b0;
      if (do_ins) begin
        valid_r[ins_idx] <= 1'b1;
        key_r[ins_idx] <= req_r.lookup_key;
        val_r[ins_idx] <= req_r.store_value;
        cnt_r[ins_idx] <= COUNT_WIDTH'(1);
        rank_r[ins_idx] <= occ_mid;
        occ_r <= occ_mid + 1'b1;
      end else begin
        occ_r <= occ_mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.hit <= hit_r;
      rsp.read_data <= (!is_put && hit_r) ? val_r[hit_idx_r] : '0;
      rsp.evicted <= do_evict;
      rsp.evicted_key <= do_evict ? key_r[vic_idx_r] : '0;
    end
  end
endmodule
`default_nettype wire

[sv/lfu_cache_lru_tiebreak_top.sv]
// Top level of the LFU cache with LRU tie break.
// Depends on lfu_pkg, lfu_if, lfu_ctrl and lfu_dp.
`default_nettype none
// A request is captured at its accepting edge, then the CAPACITY entries are
// scanned one a cycle (finding the match, the victim and the first free
// slot), and a commit step applies the update and loads the result
// register. The result becomes valid and the input is ready again in the
// same cycle; a new request is not taken until the last one is committed.
// A stalled output holds the commit until the previous result has been taken.
module lfu_cache_lru_tiebreak_top #(
  parameter int CAPACITY    = lfu_pkg::CAPACITY_DEF,
  parameter int COUNT_WIDTH = lfu_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  lfu_req_if.sink                            in_ch,
  lfu_rsp_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [lfu_pkg::CAP_CFG_W-1:0] cfg_wdata
);
  import lfu_pkg::*;

  logic [CAP_CFG_W-1:0] cap_r;
  logic out_valid_r;
  logic idle, in_fire, out_busy;
  lfu_cmd_t cmd;
  lfu_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= CAP_RESET;
    else if (cfg_we) cap_r <= cfg_wdata;
  end

  assign in_ch.ready = idle;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_busy = out_valid_r && !out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.commit) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end
  assign out_ch.valid = out_valid_r;

  lfu_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_busy, .sts, .cmd, .idle
  );

  lfu_dp #(.CAPACITY(CAPACITY), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk, .rst_n, .cmd, .req(in_ch.data), .cap_cfg(cap_r), .sts, .rsp(out_ch.data)
  );

  a_commit_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan && sts.scan_done) |=> !in_ch.ready) else $error("request accepted mid-operation");
  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !out_busy) else $error("result overwritten");
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.scan, cmd.commit})) else $error("command overlap");
endmodule
`default_nettype wire

[verif/tb_lfu_cache_lru_tiebreak_top.sv]
// Testbench for the LFU cache with LRU tie break: directed and random get/put
// requests, checked against a behavioural predictor. Depends on lfu_pkg, lfu_if
// and lfu_cache_lru_tiebreak_top.
`timescale 1ns / 100ps

class lfu_scoreboard;
  localparam int NSLOT = 16;
  localparam int CNT_MAX = 65535;
  bit [4:0] cap_reg;
  bit slot_valid[NSLOT];
  bit [31:0] slot_key[NSLOT];
  bit [31:0] slot_val[NSLOT];
  int unsigned slot_cnt[NSLOT];
  int unsigned slot_rank[NSLOT];
  int unsigned n_used;
  lfu_pkg::rsp_t pending[$];
  int errors;
  int n_hits, n_evicts, n_checked;

  function new();
    cap_reg = lfu_pkg::CAP_RESET;
    n_used = 0;
    errors = 0;
    foreach (slot_valid[i]) slot_valid[i] = 0;
  endfunction

  function void set_capacity(bit [4:0] v);
    cap_reg = v;
  endfunction

  function void bump(int s);
    int unsigned r;
    r = slot_rank[s];
    for (int j = 0; j < NSLOT; j++)
      if (slot_valid[j] && slot_rank[j] > r) slot_rank[j]--;
    slot_rank[s] = (n_used > 0) ? n_used - 1 : 0;
    if (slot_cnt[s] < CNT_MAX) slot_cnt[s]++;
  endfunction

  function void note_request(lfu_pkg::req_t q);
    lfu_pkg::rsp_t r;
    int s, v, f;
    int unsigned cap;
    cap = (cap_reg > NSLOT) ? NSLOT : cap_reg;
    s = -1;
    for (int i = 0; i < NSLOT; i++)
      if (s < 0 && slot_valid[i] && slot_key[i] == q.lookup_key) s = i;
    r = '0;
    r.hit = (s >= 0);
    if (q.cmd == lfu_pkg::CMD_GET) begin
      if (s >= 0) begin
        bump(s);
        r.read_data = slot_val[s];
      end
    end else if (cap > 0) begin
      if (s >= 0) begin
        slot_val[s] = q.store_value;
        bump(s);
      end else begin
        if (n_used >= cap) begin
          v = -1;
          for (int i = 0; i < NSLOT; i++)
            if (slot_valid[i] && (v < 0 || slot_cnt[i] < slot_cnt[v] ||
                (slot_cnt[i] == slot_cnt[v] && slot_rank[i] < slot_rank[v])))
              v = i;
          if (v >= 0) begin
            r.evicted = 1;
            r.evicted_key = slot_key[v];
            slot_valid[v] = 0;
            for (int j = 0; j < NSLOT; j++)
              if (slot_valid[j] && slot_rank[j] > slot_rank[v]) slot_rank[j]--;
            if (n_used > 0) n_used--;
          end
        end
        f = -1;
        for (int i = 0; i < NSLOT; i++)
          if (f < 0 && !slot_valid[i]) f = i;
        if (f >= 0) begin
          slot_valid[f] = 1;
          slot_key[f] = q.lookup_key;
          slot_val[f] = q.store_value;
          slot_cnt[f] = 1;
          slot_rank[f] = n_used;
          n_used++;
        end
      end
    end
    if (r.hit) n_hits++;
    if (r.evicted) n_evicts++;
    pending = {pending, r};
  endfunction

  function void check_result(lfu_pkg::rsp_t a);
    lfu_pkg::rsp_t e;
    n_checked++;
    if (pending.size() == 0) begin
      $error("result with no request outstanding");
      errors++;
      return;
    end
    e = pending[0];
    pending.delete(0);
    if (a.hit !== e.hit) begin
      $error("hit: expected %0d actual %0d", e.hit, a.hit); errors++;
    end
    if (a.read_data !== e.read_data) begin
      $error("read_data: expected %0d actual %0d", e.read_data, a.read_data); errors++;
    end
    if (a.evicted !== e.evicted) begin
      $error("evicted: expected %0d actual %0d", e.evicted, a.evicted); errors++;
    end
    if (a.evicted_key !== e.evicted_key) begin
      $error("evicted_key: expected %0d actual %0d", e.evicted_key, a.evicted_key);
      errors++;
    end
  endfunction
endclass

module tb_lfu_cache_lru_tiebreak_top;
  import lfu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CAP_CFG_W-1:0] cfg_wdata = '0;
  int send_idle = 0, recv_idle = 0;
  int cycles = 0;
  lfu_scoreboard sb;

  lfu_req_if in_ch();
  lfu_rsp_if out_ch();

  lfu_cache_lru_tiebreak_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // receiver: random stalls, result checked at the accepting edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // valid stays high after acceptance; the next request or drain() replaces it
  task automatic send(logic c, logic [31:0] k, logic [31:0] v);
    req_t q;
    q.cmd = c;
    q.lookup_key = k;
    q.store_value = v;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= q;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(q);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_capacity(logic [4:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_capacity(v);
  endtask

  // mostly keys from a small pool so that hits, ties and evictions happen
  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(9);
    if (r < 8) return 32'($urandom_range(23)) - 32'd4;
    return $urandom;
  endfunction

  task automatic random_burst(int n);
    for (int i = 0; i < n; i++)
      send(($urandom_range(1) ? CMD_PUT : CMD_GET), pick_key(), $urandom);
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, misses, updates, full-cache eviction with tie
    send(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send(CMD_GET, 32'h8000_0000, 0);
    send(CMD_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send(CMD_GET, 32'h7FFF_FFFF, 0);
    send(CMD_GET, 32'hFFFF_FFFF, 0);
    write_capacity(5'd2);
    send(CMD_PUT, 0, 1);          // evicts lowest count, oldest touch
    send(CMD_PUT, 1, 2);
    send(CMD_GET, 0, 0);
    write_capacity(5'd0);         // puts ignored
    send(CMD_PUT, 0, 9);
    send(CMD_PUT, 5, 9);
    send(CMD_GET, 0, 0);
    write_capacity(5'd31);        // saturates to full size
    for (int i = 0; i < 17; i++) send(CMD_PUT, 100 + i, i);
    write_capacity(5'd1);         // below occupancy
    send(CMD_PUT, 200, 0);
    write_capacity(5'd16);
    send(CMD_PUT, 201, 1);

    send_idle = 29; recv_idle = 83;
    random_burst(400);
    write_capacity(5'($urandom_range(16, 1)));
    send_idle = 83; recv_idle = 29;
    random_burst(400);
    write_capacity(5'd3);
    send_idle = 0; recv_idle = 0;
    random_burst(400);
    write_capacity(5'd16);
    random_burst(400);

    drain();
    $display("Checked %0d results: %0d hits, %0d evictions, capacities 0 to 31.",
             sb.n_checked, sb.n_hits, sb.n_evicts);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
